### rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants for the trial-division prime test
// Holds the field widths, the controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   // Width of the number under test.
   localparam int NUM_BITS = 31;
   // Trial divisors never exceed about sqrt(2^NUM_BITS) + 2.
   localparam int DIV_BITS = (NUM_BITS + 1) / 2 + 1;
   // Width of the running square of the divisor.
   localparam int SQ_BITS  = 2 * DIV_BITS;
   // Bit counter of the serial remainder unit.
   localparam int CNT_BITS = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

   localparam int FIRST_DIV = 3;
   localparam int FIRST_SQ  = FIRST_DIV * FIRST_DIV;

   typedef logic [NUM_BITS-1:0] num_type;
   typedef logic [DIV_BITS-1:0] div_type;
   typedef logic [SQ_BITS-1:0]  sq_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_TEST,
      ST_DIVIDE,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture a new request, divisor back to three
      logic start_div;  // clear the remainder and start a serial pass
      logic div_step;   // one bit of the serial remainder
      logic next_div;   // step to the next odd divisor
      logic out_load;   // load the result register
      logic out_value;  // value for the result register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic n_lt2;
      logic n_is2;
      logic n_even;
      logic sq_lt_n;
      logic sq_eq_n;
      logic div_last;
      logic rem_zero;
   } status_type;

endpackage

### rtl/tdpt_req_if.sv
// ----------------------------------------------------------------------------
// tdpt_req_if: request channel of the prime test
// Valid/ready handshake carrying the number to be tested.
// ----------------------------------------------------------------------------
interface tdpt_req_if;
   import tdpt_pkg::*;

   logic    valid;
   logic    ready;
   num_type number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

### rtl/tdpt_rsp_if.sv
// ----------------------------------------------------------------------------
// tdpt_rsp_if: response channel of the prime test
// Valid/ready handshake carrying the one-bit verdict.
// ----------------------------------------------------------------------------
interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink   (input valid, input is_prime, output ready);
endinterface

### rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl: sequencer of the prime test
// Walks one request through classification, the divisor loop and the
// serial remainder passes, and owns the handshakes on both channels.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tdpt_pkg::status_type status,
   output tdpt_pkg::cmd_type    cmd
);
   import tdpt_pkg::*;

   state_type state_ff, state_in;
   logic      verdict_ff, verdict_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         verdict_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         verdict_ff   <= verdict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      logic out_free;
      logic decide;
      logic dec_value;

      out_free     = !rsp_valid_ff || rsp_ready;
      decide       = 1'b0;
      dec_value    = 1'b0;
      cmd          = '0;
      state_in     = state_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (status.n_lt2) begin
               decide = 1'b1;
            end else if (status.n_is2) begin
               decide    = 1'b1;
               dec_value = 1'b1;
            end else if (status.n_even) begin
               decide = 1'b1;
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.sq_lt_n) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               // Loop is over: prime unless the number is the divisor squared.
               decide    = 1'b1;
               dec_value = !status.sq_eq_n;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.rem_zero) begin
               decide = 1'b1;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_TEST;
            end
         end
         ST_FINISH: begin
            decide    = 1'b1;
            dec_value = verdict_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A verdict goes straight to the result register when it is free,
      // otherwise it waits in the finish state.
      if (decide) begin
         if (out_free) begin
            cmd.out_load  = 1'b1;
            cmd.out_value = dec_value;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end else begin
            verdict_in = dec_value;
            state_in   = ST_FINISH;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/tdpt_dpath.sv
// ----------------------------------------------------------------------------
// tdpt_dpath: datapath of the prime test
// Holds the number, the odd trial divisor and its running square, a
// bit-serial restoring remainder unit and the result register.
// ----------------------------------------------------------------------------
module tdpt_dpath (
   input  logic                 clock,
   input  tdpt_pkg::num_type    number,
   input  tdpt_pkg::cmd_type    cmd,
   output tdpt_pkg::status_type status,
   output logic                 is_prime
);
   import tdpt_pkg::*;

   num_type n_ff, n_in;
   num_type shift_ff, shift_in;
   div_type d_ff, d_in;
   div_type rem_ff, rem_in;
   sq_type  sq_ff, sq_in;
   cnt_type cnt_ff, cnt_in;
   logic    is_prime_ff, is_prime_in;

   logic [DIV_BITS:0] trial;
   logic [DIV_BITS:0] diff;

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      shift_ff    <= shift_in;
      d_ff        <= d_in;
      rem_ff      <= rem_in;
      sq_ff       <= sq_in;
      cnt_ff      <= cnt_in;
      is_prime_ff <= is_prime_in;
   end

   // One restoring step: bring in the next bit of the number, subtract
   // the divisor when it fits.
   assign trial = {rem_ff, shift_ff[NUM_BITS-1]};
   assign diff  = trial - {1'b0, d_ff};

   always_comb begin
      n_in        = n_ff;
      shift_in    = shift_ff;
      d_in        = d_ff;
      rem_in      = rem_ff;
      sq_in       = sq_ff;
      cnt_in      = cnt_ff;
      is_prime_in = is_prime_ff;

      if (cmd.load) begin
         n_in  = number;
         d_in  = DIV_BITS'(FIRST_DIV);
         sq_in = SQ_BITS'(FIRST_SQ);
      end
      if (cmd.start_div) begin
         shift_in = n_ff;
         rem_in   = '0;
         cnt_in   = '0;
      end
      if (cmd.div_step) begin
         shift_in = {shift_ff[NUM_BITS-2:0], 1'b0};
         rem_in   = diff[DIV_BITS] ? trial[DIV_BITS-1:0] : diff[DIV_BITS-1:0];
         cnt_in   = cnt_ff + 1'b1;
      end
      if (cmd.next_div) begin
         // (d + 2)^2 = d^2 + 4d + 4
         d_in  = d_ff + DIV_BITS'(2);
         sq_in = sq_ff + SQ_BITS'({d_ff, 2'b00}) + SQ_BITS'(4);
      end
      if (cmd.out_load) begin
         is_prime_in = cmd.out_value;
      end
   end

   assign status.n_lt2    = (n_ff[NUM_BITS-1:1] == '0);
   assign status.n_is2    = (n_ff == NUM_BITS'(2));
   assign status.n_even   = !n_ff[0];
   assign status.sq_lt_n  = (sq_ff < SQ_BITS'(n_ff));
   assign status.sq_eq_n  = (sq_ff == SQ_BITS'(n_ff));
   assign status.div_last = (cnt_ff == CNT_BITS'(NUM_BITS - 1));
   assign status.rem_zero = (rem_ff == '0);

   assign is_prime = is_prime_ff;

endmodule

### rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Reports for each request whether its 31-bit number is prime.
// ----------------------------------------------------------------------------
// Usage. Each request on req_ch carries one unsigned number; each response
// on rsp_ch carries one bit, is_prime, in request order. Zero and one are
// reported as not prime, two as prime, and other even numbers as not prime.
// Odd numbers are divided by 3, 5, 7, ... while the divisor squared is below
// the number; an exact division or an exact square makes them composite.
// The block works on one request at a time. A request is taken only while
// the sequencer is idle, so req_ch.ready is low while a number is tested.
// Zero, one and even numbers are answered straight from the classify state.
// An odd number runs the divisor loop once for each of its trial divisors;
// each divisor costs one pass of the bit-serial remainder unit over all
// NUM_BITS bits plus a test and a check state. The worst case, a 31-bit
// prime, tries about 23170 divisors.
// The response sits in an output register; while the receiver stalls it is
// held, and a new request is still accepted. A finished verdict waits in the
// sequencer until the output register frees up. Synchronous reset returns
// the sequencer to idle and drops rsp_ch.valid; the datapath is not reset.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
   input  logic  clock,
   input  logic  reset,
   tdpt_req_if.sink   req_ch,
   tdpt_rsp_if.source rsp_ch
);
   import tdpt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The sequencer decides what happens each cycle and owns both handshakes.
   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the number, the divisor, its square, the serial
   // remainder and the response register.
   tdpt_dpath u_dpath (
      .clock    (clock),
      .number   (req_ch.number),
      .cmd      (cmd),
      .status   (status),
      .is_prime (rsp_ch.is_prime)
   );

endmodule

### rtl/tdpt_checker.sv
// ----------------------------------------------------------------------------
// tdpt_checker: port-level checks of the prime test
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tdpt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input tdpt_pkg::num_type     req_number,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_is_prime
);
   import tdpt_pkg::*;

   logic req_fire;
   logic trivial_no;

   assign req_fire   = req_valid && req_ready;
   assign trivial_no = (req_number == NUM_BITS'(0)) || (req_number == NUM_BITS'(1)) ||
                       (!req_number[0] && (req_number != NUM_BITS'(2)));

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_prime))
      else $error("response changed while stalled");

   // One request at a time: the block is busy right after taking one.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while a number is under test");

   // Zero, one and even numbers other than two answer not prime when the output is free.
   a_trivial: assert property (@(posedge clock) disable iff (reset)
      req_fire && !rsp_valid && trivial_no |=> ##1 rsp_valid && !rsp_is_prime)
      else $error("trivial composite not reported in time");

   // Two answers prime when the output is free.
   a_two: assert property (@(posedge clock) disable iff (reset)
      req_fire && !rsp_valid && (req_number == NUM_BITS'(2))
      |=> ##1 rsp_valid && rsp_is_prime)
      else $error("two not reported as prime");

   // A new response only appears when the sequencer returns to idle.
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response raised while still busy");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_number   (req_ch.number),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_is_prime (rsp_ch.is_prime)
);

### sim/prime_verdict_checker.sv
// ----------------------------------------------------------------------------
// prime_verdict_checker: request/response scoreboard for the prime test
// Watches both channels, predicts each verdict by trial division on its own
// and compares every response against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module prime_verdict_checker (
   input  logic clock,
   input  logic reset,
   tdpt_req_if  req_ch,
   tdpt_rsp_if  rsp_ch,
   output int   mismatches,
   output int   awaiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import tdpt_pkg::*;

   typedef struct {
      num_type number;
      logic    is_prime;
   } verdict_type;

   verdict_type verdict_queue[$];

   // Trial division over 64 bits, so the divisor square cannot wrap.
   function automatic logic predict_is_prime(num_type n);
      longint unsigned value;
      longint unsigned divisor;
      value   = n;
      divisor = 3;
      if (value < 2) return 1'b0;
      if (value == 2) return 1'b1;
      if (value[0] == 1'b0) return 1'b0;
      while (divisor * divisor < value) begin
         if (value % divisor == 0) return 1'b0;
         divisor += 2;
      end
      return (divisor * divisor != value);
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t verdict check: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      verdict_type head;
      if (reset) begin
         mismatches = 0;
         awaiting   = 0;
      end else begin
         // Retire before capturing, so a response can never match a request
         // accepted at the same edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch($sformatf("response is_prime=%0b with no request waiting",
                                         rsp_ch.is_prime));
            end else begin
               head = verdict_queue.pop_front();
               if (rsp_ch.is_prime !== head.is_prime)
                  report_mismatch($sformatf("number %0d: is_prime=%0b, predicted %0b",
                                            head.number, rsp_ch.is_prime, head.is_prime));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            head.number   = req_ch.number;
            head.is_prime = predict_is_prime(req_ch.number);
            verdict_queue.push_back(head);
         end
         awaiting = verdict_queue.size();
      end
   end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: top level of the prime test simulation
// Drives numbers into the block and random back-pressure on its responses;
// a separate checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tdpt_pkg::*;

   logic clock;
   logic reset;

   tdpt_req_if req_ch();
   tdpt_rsp_if rsp_ch();

   int mismatches;
   int awaiting;

   // A request is accepted at a rising edge with valid and ready both high.
   // This flag records that edge so the stimulus can see it at the next
   // falling edge without racing the block's own updates.
   logic request_taken;

   // While a flag is set, that side of the channel never idles.
   bit sender_calm;
   bit sink_calm;
   int stall_left = 0;

   trial_division_prime_test dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   prime_verdict_checker verdict_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   // 10 ns clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      request_taken <= req_ch.valid && req_ch.ready;
   end

   // Response side. Stalls come in random bursts; since an odd number keeps
   // the block busy through its whole divisor loop, the bursts land on every
   // phase of its work, including while a finished verdict is waiting for the
   // output register to free up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!sink_calm && $urandom_range(0, 7) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 4);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Offer one number and hold it until the block takes it. Afterwards the
   // sender may go quiet for a short burst, putting junk on the number lines
   // so that a stray capture would show up as a wrong verdict.
   task automatic send_number(num_type n);
      int gap;
      req_ch.valid  <= 1'b1;
      req_ch.number <= n;
      do @(negedge clock); while (!request_taken);
      if (!sender_calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_ch.valid  <= 1'b0;
         req_ch.number <= num_type'($urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drops valid and waits until every response has come back. The first
   // wait is unconditional so that valid is never driven twice in one step.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (awaiting != 0);
   endtask

   initial begin
      // Corner numbers: zero and one (not prime), two (the only even prime),
      // small odd primes and squares of primes, the largest 16-bit prime, a
      // 20-bit prime and a 20-bit prime square that make the divisor loop run
      // long, and the top of the field. The all-ones value is itself prime
      // and is the slowest number the block can be given.
      num_type corner_numbers[$] = '{
         31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd8, 31'd9, 31'd15,
         31'd25, 31'd49, 31'd97, 31'd121, 31'd169, 31'd65521, 31'd1018081,
         31'd1048573, 31'd715827882, 31'd1431655765, 31'd2147483645,
         31'd2147483646, 31'd2147483647
      };
      num_type     n;
      int unsigned factor_a;
      int unsigned factor_b;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.number  = '0;
      sender_calm    = 1'b1;
      sink_calm      = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (corner_numbers[i])
         send_number(corner_numbers[i]);

      // Random part. Large odd primes run the whole divisor loop up to their
      // square root, so big numbers are built to be even or to carry a small odd
      // factor; the divisor loop then stops early while all 31 bits still toggle.
      // Small and medium numbers exercise full runs of the loop, primes and
      // squares included.
      sender_calm = 1'b0;
      for (int i = 0; i < 100; i++) begin
         sink_calm   = (i >= 40 && i < 60) || i >= 80;
         sender_calm = (i >= 80);

         // Once mid-run, let the block empty out completely before going on.
         if (i == 50)
            drain_responses();

         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               n = num_type'($urandom_range(0, 4095));
            end
            4: begin
               n = num_type'($urandom_range(4096, 65535));
            end
            5, 6: begin
               n    = num_type'($urandom);
               n[0] = 1'b0;
            end
            7, 8: begin
               factor_a = 2 * $urandom_range(1, 15) + 1;
               factor_b = $urandom_range(1, 32'h7fff_ffff / factor_a);
               n        = num_type'(factor_a * factor_b);
            end
            default: begin
               // Product of two odd numbers below 256, often a prime square
               // or a product of two primes close together.
               factor_a = 2 * $urandom_range(1, 127) + 1;
               factor_b = 2 * $urandom_range(1, 127) + 1;
               n        = num_type'(factor_a * factor_b);
            end
         endcase
         send_number(n);
      end

      drain_responses();
      // Leave room for any stray response to show up.
      repeat (20) @(negedge clock);

      if (mismatches == 0 && awaiting == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // The all-ones number is the longest single test of the run. This watchdog
   // ends the simulation with a failure if the run has not finished first.
   initial begin
      #80_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
